// File: rtl/core/note_to_pwm_timer_setup_defines.svh
// Assertion macros shared by the note-to-PWM checker.
`ifndef NOTE_TO_PWM_TIMER_SETUP_DEFINES_SVH
`define NOTE_TO_PWM_TIMER_SETUP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define NTPWM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ntpwm check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define NTPWM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ntpwm check failed");

`endif

// File: rtl/core/ntpwm_pkg.sv
// Types and constants for the note-to-PWM timer setup block.
`default_nettype none

package ntpwm_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_CLASS,
    ST_DIV,
    ST_PRE,
    ST_DONE
  } state_t;

  // range_class codes
  localparam logic [1:0] CLS_NONE = 2'd0;
  localparam logic [1:0] CLS_SLOW = 2'd1;
  localparam logic [1:0] CLS_FAST = 2'd2;

  // ASCII note letters
  localparam logic [7:0] LETTER_A = 8'h41;
  localparam logic [7:0] LETTER_B = 8'h42;
  localparam logic [7:0] LETTER_D = 8'h44;
  localparam logic [7:0] LETTER_E = 8'h45;
  localparam logic [7:0] LETTER_F = 8'h46;
  localparam logic [7:0] LETTER_G = 8'h47;

  localparam int INT_W   = 16;      // integer bits of the frequency accumulator
  localparam int CHUNK_W = 16;      // multiplicand digit per multiply cycle
  localparam int DIV_W   = 24;      // dividend bits, covers 16 MHz
  localparam int DIV_CNT_W = 5;

  localparam logic [15:0] BASE_HZ  = 16'd130;
  localparam logic [15:0] SLOW_LOW = 16'd127;
  localparam logic [15:0] FAST_LOW = 16'd490;
  localparam logic [15:0] FAST_END = 16'd4200;
  localparam logic [DIV_W-1:0] SLOW_CLK = 24'd31000;
  localparam logic [DIV_W-1:0] FAST_CLK = 24'd16000000;
  localparam logic [2:0] PRE_MAX = 3'd7;

  // semitones above C; unknown letters count as C
  function automatic logic [3:0] letter_offset(input logic [7:0] c);
    logic [3:0] r;
    unique case (c)
      LETTER_D: r = 4'd2;
      LETTER_E: r = 4'd4;
      LETTER_F: r = 4'd5;
      LETTER_G: r = 4'd7;
      LETTER_A: r = 4'd9;
      LETTER_B: r = 4'd11;
      default:  r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/note_to_pwm_timer_setup.sv
// Note to PWM timer setup: equal-tempered frequency, timer clock, period and duty.
`default_nettype none
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  in      | into      | in_valid / in_stall  | note_letter, accidental, octave_number
//  out     | out of    | out_valid / out_stall| range_class, frequency_hz, prescale_log2,
//          |           |                      | period_count, duty_count
//
//  Steps per transaction: accept, then s times a multiply over NCH digits and an add, s the
//  positive semitone count (0..26), NCH = ceil((16+RATIO_FRAC_BITS)/16), 3 at default; then
//  classify; for a tone a divide, and on the fast clock a prescale; then done.
//  in_stall is high from accept until the result is loaded; a stalled result holds DONE.
//  rst is synchronous, active high, and clears the sequencer and out_valid only.
//  A finished result sits in the output register; a new input is taken while it waits.
//
module note_to_pwm_timer_setup #(
  parameter int RATIO_FRAC_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  note_letter,
  input  wire logic [4:0]  accidental,
  input  wire logic [2:0]  octave_number,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       range_class,
  output logic [15:0]      frequency_hz,
  output logic [2:0]       prescale_log2,
  output logic [7:0]       period_count,
  output logic [6:0]       duty_count
);

  // accumulator: INT_W integer bits above RATIO_FRAC_BITS fraction bits
  localparam int F      = RATIO_FRAC_BITS;
  localparam int ACC_W  = ntpwm_pkg::INT_W + F;
  localparam int CH_W   = ntpwm_pkg::CHUNK_W;
  localparam int NCH    = (ACC_W + CH_W - 1) / CH_W;   // digits per multiply
  localparam int PAD_W  = NCH * CH_W;
  localparam int PP_W   = CH_W + F;
  localparam int PROD_W = PAD_W + F;
  localparam int CNT_W  = $clog2(NCH + 1);

  // ratio = round(1.0594631 * 2^F); only its fraction rf is multiplied
  localparam logic [63:0] RATIO_FULL =
    ((64'd10594631 << F) + 64'd5000000) / 64'd10000000;
  localparam logic [F-1:0] RF = RATIO_FULL[F-1:0];

  ntpwm_pkg::state_t state, state_next;

  logic [ACC_W-1:0]  acc;        // frequency, fixed point
  logic [PAD_W-1:0]  mreg;       // multiplicand digits, MSB digit first
  logic [PP_W-1:0]   pp;         // registered partial product
  logic [PROD_W-1:0] prod;       // acc * rf, built digit by digit
  logic [CNT_W-1:0]  cnt;
  logic [4:0]        steps;      // semitones still to apply
  logic [1:0]        cls;
  logic [15:0]       f_hz;
  logic [15:0]       rem;        // divider remainder
  logic [ntpwm_pkg::DIV_W-1:0] quo;   // dividend in, quotient out, then prescaled
  logic [ntpwm_pkg::DIV_CNT_W-1:0] dcnt;
  logic [2:0]        pre;

  logic              accept;
  logic              out_load;
  logic [3:0]        off4;
  logic signed [5:0] steps6;
  logic [15:0]       base_hz;
  logic [ACC_W-1:0]  acc_sum;
  logic [15:0]       fr;
  logic [16:0]       trial;
  logic              borrow;

  assign in_stall = (state != ntpwm_pkg::ST_IDLE);
  assign accept   = in_valid && (state == ntpwm_pkg::ST_IDLE);
  assign out_load = (state == ntpwm_pkg::ST_DONE) && (!out_valid || !out_stall);

  // semitone count: letter offset plus signed accidental, range -16..26
  assign off4    = ntpwm_pkg::letter_offset(note_letter);
  assign steps6  = $signed({2'b00, off4}) + $signed({accidental[4], accidental});
  assign base_hz = (octave_number > 3'd2) ?
                   (ntpwm_pkg::BASE_HZ << (octave_number - 3'd2)) : ntpwm_pkg::BASE_HZ;

  // one semitone: acc + floor(acc * rf / 2^F)
  assign acc_sum = acc + prod[F +: ACC_W];
  assign fr      = acc[F +: 16];

  // restoring divide step, one quotient bit per cycle
  assign trial  = {rem, quo[ntpwm_pkg::DIV_W-1]} - {1'b0, f_hz};
  assign borrow = trial[16];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ntpwm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ntpwm_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = (steps6 > 6'sd0) ? ntpwm_pkg::ST_MUL : ntpwm_pkg::ST_CLASS;
        end
      end
      ntpwm_pkg::ST_MUL: begin
        if (cnt == CNT_W'(NCH)) state_next = ntpwm_pkg::ST_ADD;
      end
      ntpwm_pkg::ST_ADD: begin
        state_next = (steps == 5'd1) ? ntpwm_pkg::ST_CLASS : ntpwm_pkg::ST_MUL;
      end
      ntpwm_pkg::ST_CLASS: begin
        if ((fr >= ntpwm_pkg::SLOW_LOW) && (fr < ntpwm_pkg::FAST_END)) begin
          state_next = ntpwm_pkg::ST_DIV;
        end else begin
          state_next = ntpwm_pkg::ST_DONE;
        end
      end
      ntpwm_pkg::ST_DIV: begin
        if (dcnt == ntpwm_pkg::DIV_CNT_W'(ntpwm_pkg::DIV_W - 1)) begin
          state_next = (cls == ntpwm_pkg::CLS_FAST) ? ntpwm_pkg::ST_PRE : ntpwm_pkg::ST_DONE;
        end
      end
      ntpwm_pkg::ST_PRE: begin
        if ((pre == ntpwm_pkg::PRE_MAX) || (quo[ntpwm_pkg::DIV_W-1:8] == '0)) begin
          state_next = ntpwm_pkg::ST_DONE;
        end
      end
      ntpwm_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) state_next = ntpwm_pkg::ST_IDLE;
      end
      default: state_next = ntpwm_pkg::ST_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ntpwm_pkg::ST_IDLE: begin
        if (accept) begin
          acc   <= ACC_W'(base_hz) << F;
          mreg  <= PAD_W'(ACC_W'(base_hz) << F);
          prod  <= '0;
          cnt   <= '0;
          steps <= steps6[4:0];
        end
      end
      ntpwm_pkg::ST_MUL: begin
        if (cnt != CNT_W'(NCH)) begin
          pp   <= PP_W'(mreg[PAD_W-1 -: CH_W]) * PP_W'(RF);
          mreg <= mreg << CH_W;
        end
        if (cnt != '0) begin
          prod <= (prod << CH_W) + PROD_W'(pp);
        end
        cnt <= cnt + 1'b1;
      end
      ntpwm_pkg::ST_ADD: begin
        acc   <= acc_sum;
        mreg  <= PAD_W'(acc_sum);
        prod  <= '0;
        cnt   <= '0;
        steps <= steps - 5'd1;
      end
      ntpwm_pkg::ST_CLASS: begin
        f_hz <= fr;
        rem  <= '0;
        dcnt <= '0;
        pre  <= '0;
        if ((fr >= ntpwm_pkg::SLOW_LOW) && (fr < ntpwm_pkg::FAST_LOW)) begin
          cls <= ntpwm_pkg::CLS_SLOW;
          quo <= ntpwm_pkg::SLOW_CLK;
        end else if ((fr >= ntpwm_pkg::FAST_LOW) && (fr < ntpwm_pkg::FAST_END)) begin
          cls <= ntpwm_pkg::CLS_FAST;
          quo <= ntpwm_pkg::FAST_CLK;
        end else begin
          cls <= ntpwm_pkg::CLS_NONE;
          quo <= '0;
        end
      end
      ntpwm_pkg::ST_DIV: begin
        rem  <= borrow ? {rem[14:0], quo[ntpwm_pkg::DIV_W-1]} : trial[15:0];
        quo  <= {quo[ntpwm_pkg::DIV_W-2:0], ~borrow};
        dcnt <= dcnt + 1'b1;
      end
      ntpwm_pkg::ST_PRE: begin
        // halve until the period fits in 8 bits or pre reaches PRE_MAX
        if ((pre != ntpwm_pkg::PRE_MAX) && (quo[ntpwm_pkg::DIV_W-1:8] != '0)) begin
          quo <= quo >> 1;
          pre <= pre + 3'd1;
        end
      end
      ntpwm_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      range_class   <= cls;
      frequency_hz  <= f_hz;
      prescale_log2 <= pre;
      period_count  <= quo[7:0];
      duty_count    <= quo[7:1];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ntpwm_checker.sv
// Port-level checks for the note-to-PWM timer setup block, bound to the top level.
`default_nettype none
`include "note_to_pwm_timer_setup_defines.svh"

module ntpwm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  range_class,
  input wire logic [15:0] frequency_hz,
  input wire logic [2:0]  prescale_log2,
  input wire logic [7:0]  period_count,
  input wire logic [6:0]  duty_count
);

  logic        out_wait;
  logic        no_tone;
  logic [35:0] out_payload;

  assign out_wait    = out_valid && out_stall;
  assign no_tone     = out_valid && (range_class == ntpwm_pkg::CLS_NONE);
  assign out_payload = {range_class, frequency_hz, prescale_log2, period_count, duty_count};

  // a held result keeps its payload
  `NTPWM_ASSERT_NEXT(a_out_hold, out_wait, out_valid && $stable(out_payload))

  // one transaction in flight: busy right after accept
  `NTPWM_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // duty is half the period
  `NTPWM_ASSERT_NOW(a_duty_half, out_valid, duty_count == period_count[7:1])

  // no tone means a cleared timer setup
  `NTPWM_ASSERT_NOW(a_no_tone_zero, no_tone, (period_count == 8'd0) && (prescale_log2 == 3'd0))

endmodule

bind note_to_pwm_timer_setup ntpwm_checker u_ntpwm_checker (.*);

`default_nettype wire

// File: tb/note_to_pwm_timer_setup_tb.sv
// Self-checking testbench for note_to_pwm_timer_setup: directed notes, then random notes.
`timescale 1ns / 1ps

module note_to_pwm_timer_setup_tb;

  // Fraction bits of the semitone ratio; the DUT gets the same value.
  localparam int FRAC = 24;
  localparam logic [7:0] LETTER_C = 8'h43;
  // Settle window after the last result, longer than the longest transaction.
  localparam int DRAIN_CYCLES = 300;
  localparam int RANDOM_NOTES = 1300;

  // One result transaction, field for field.
  typedef struct packed {
    logic [1:0]  range_class;
    logic [15:0] frequency_hz;
    logic [2:0]  prescale_log2;
    logic [7:0]  period_count;
    logic [6:0]  duty_count;
  } timer_setup_t;

  // Holds the expected timer setups in order and checks each result against the oldest.
  class setup_scoreboard;
    timer_setup_t pending_setups[$];
    int unsigned  mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Equal-tempered frequency and timer setup for one note.
    function timer_setup_t predict_timer_setup(logic [7:0] letter, logic [4:0] accidental,
                                               logic [2:0] octave);
      timer_setup_t       r;
      longint unsigned    one, mask, ratio_frac, fx, hi, lo;
      int                 steps;
      int                 acc_i;
      int unsigned        f, p, k;
      one        = 64'd1 << FRAC;
      mask       = one - 64'd1;
      ratio_frac = (64'd10594631 * one + 64'd5000000) / 64'd10000000 - one;
      acc_i      = $signed(accidental);
      case (letter)
        ntpwm_pkg::LETTER_D: steps = 2;
        ntpwm_pkg::LETTER_E: steps = 4;
        ntpwm_pkg::LETTER_F: steps = 5;
        ntpwm_pkg::LETTER_G: steps = 7;
        ntpwm_pkg::LETTER_A: steps = 9;
        ntpwm_pkg::LETTER_B: steps = 11;
        default:  steps = 0;
      endcase
      steps = steps + acc_i;
      // Base doubles once per octave above 2; lower octaves keep the base.
      f = 130;
      if (octave > 3'd2) f = 130 << (octave - 3'd2);
      fx = longint'(f) << FRAC;
      // Zero or negative semitone count: no multiply at all.
      for (int i = 0; i < steps; i++) begin
        hi = fx >> FRAC;
        lo = fx & mask;
        fx = fx + hi * ratio_frac + ((lo * ratio_frac) >> FRAC);
      end
      f = int'(fx >> FRAC);
      r = '0;
      r.frequency_hz = f[15:0];
      if (f >= 127 && f < 490) begin
        r.range_class  = ntpwm_pkg::CLS_SLOW;
        r.period_count = 8'(31000 / f);
      end else if (f >= 490 && f < 4200) begin
        p = 16000000 / f;
        k = 0;
        while (k < 7 && (p >> k) > 255) k++;
        r.range_class   = ntpwm_pkg::CLS_FAST;
        r.prescale_log2 = 3'(k);
        r.period_count  = 8'(p >> k);
      end
      r.duty_count = r.period_count[7:1];
      return r;
    endfunction

    function void note_input(logic [7:0] letter, logic [4:0] accidental, logic [2:0] octave);
      pending_setups.push_back(predict_timer_setup(letter, accidental, octave));
    endfunction

    function void check_result(timer_setup_t got);
      timer_setup_t want;
      if (pending_setups.size() == 0) begin
        $display("%0t: result with none expected: class %0d freq %0d pre %0d per %0d duty %0d",
                 $time, got.range_class, got.frequency_hz, got.prescale_log2,
                 got.period_count, got.duty_count);
        mismatches++;
        return;
      end
      want = pending_setups.pop_front();
      if (got.range_class !== want.range_class) begin
        $display("%0t: range_class expected %0d actual %0d", $time,
                 want.range_class, got.range_class);
        mismatches++;
      end
      if (got.frequency_hz !== want.frequency_hz) begin
        $display("%0t: frequency_hz expected %0d actual %0d", $time,
                 want.frequency_hz, got.frequency_hz);
        mismatches++;
      end
      if (got.prescale_log2 !== want.prescale_log2) begin
        $display("%0t: prescale_log2 expected %0d actual %0d", $time,
                 want.prescale_log2, got.prescale_log2);
        mismatches++;
      end
      if (got.period_count !== want.period_count) begin
        $display("%0t: period_count expected %0d actual %0d", $time,
                 want.period_count, got.period_count);
        mismatches++;
      end
      if (got.duty_count !== want.duty_count) begin
        $display("%0t: duty_count expected %0d actual %0d", $time,
                 want.duty_count, got.duty_count);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  note_letter = '0;
  logic [4:0]  accidental = '0;
  logic [2:0]  octave_number = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  range_class;
  logic [15:0] frequency_hz;
  logic [2:0]  prescale_log2;
  logic [7:0]  period_count;
  logic [6:0]  duty_count;

  // Idle and stall odds in percent, changed per phase.
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  setup_scoreboard sb = new();

  note_to_pwm_timer_setup #(
    .RATIO_FRAC_BITS(FRAC)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .note_letter(note_letter),
    .accidental(accidental),
    .octave_number(octave_number),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .range_class(range_class),
    .frequency_hz(frequency_hz),
    .prescale_log2(prescale_log2),
    .period_count(period_count),
    .duty_count(duty_count)
  );

  always #2 clk = ~clk;

  // Receiver: stall decided at the falling edge, so it is stable at the rising edge.
  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Result monitor: a transaction completes at a rising edge with valid high, stall low.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result({range_class, frequency_hz, prescale_log2, period_count, duty_count});
  end

  // Offer one note; entered and left at a falling edge. Payload holds while stalled.
  task automatic send_note(input logic [7:0] letter, input logic [4:0] acc,
                           input logic [2:0] octave);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    note_letter   <= letter;
    accidental    <= acc;
    octave_number <= octave;
    do @(posedge clk); while (in_stall);
    sb.note_input(letter, acc, octave);
    @(negedge clk);
  endtask

  // Sender goes quiet until every expected setup has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending_setups.size() != 0) @(negedge clk);
  endtask

  // Mostly real letters and in-range accidentals; some raw bytes and raw 5-bit offsets.
  task automatic send_random_notes(input int count);
    logic [7:0] letter;
    logic [4:0] acc;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(9))
        0: letter = ntpwm_pkg::LETTER_A;
        1: letter = ntpwm_pkg::LETTER_B;
        2: letter = LETTER_C;
        3: letter = ntpwm_pkg::LETTER_D;
        4: letter = ntpwm_pkg::LETTER_E;
        5: letter = ntpwm_pkg::LETTER_F;
        6: letter = ntpwm_pkg::LETTER_G;
        default: letter = 8'($urandom_range(255));
      endcase
      if ($urandom_range(3) == 0) acc = 5'($urandom_range(31));
      else acc = 5'($urandom_range(24) - 12);
      send_note(letter, acc, 3'($urandom_range(7)));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed notes, no idling: octaves below and at 2, every letter, unknown codes,
    // flats down to or below C, raw accidentals outside -12..12, highest frequency.
    send_note(LETTER_C, 5'd0, 3'd0);
    send_note(LETTER_C, 5'd0, 3'd1);
    send_note(LETTER_C, 5'd0, 3'd2);
    send_note(ntpwm_pkg::LETTER_A, 5'd0, 3'd3);
    send_note(ntpwm_pkg::LETTER_A, 5'd0, 3'd4);
    send_note(ntpwm_pkg::LETTER_B, 5'd0, 3'd4);
    send_note(LETTER_C, 5'd0, 3'd4);
    send_note(ntpwm_pkg::LETTER_D, 5'd0, 3'd4);
    send_note(ntpwm_pkg::LETTER_E, 5'd0, 3'd4);
    send_note(ntpwm_pkg::LETTER_F, 5'd0, 3'd4);
    send_note(ntpwm_pkg::LETTER_G, 5'd0, 3'd4);
    send_note(ntpwm_pkg::LETTER_B, 5'b01111, 3'd7);   // largest count, top octave
    send_note(LETTER_C, 5'b10000, 3'd7);              // most negative raw accidental
    send_note(8'h00, 5'd0, 3'd5);                     // unknown code counts as C
    send_note(8'hFF, 5'b01111, 3'd3);
    send_note(8'h61, 5'd3, 3'd7);                     // lowercase is not a letter here
    send_note(LETTER_C, 5'b11111, 3'd4);              // flat below C: no multiply
    send_note(ntpwm_pkg::LETTER_D, 5'b11110, 3'd5);   // exactly zero semitones
    send_note(ntpwm_pkg::LETTER_G, 5'd12, 3'd6);
    send_note(ntpwm_pkg::LETTER_E, 5'b10100, 3'd0);   // -12
    send_note(ntpwm_pkg::LETTER_F, 5'b10000, 3'd1);
    send_note(ntpwm_pkg::LETTER_A, 5'd12, 3'd7);
    drain_results();

    // Random notes over four phases of idle and stall odds; the sender drains between phases.
    send_random_notes(RANDOM_NOTES / 4);
    drain_results();
    idle_pct = 53;
    send_random_notes(RANDOM_NOTES / 4);
    drain_results();
    idle_pct  = 0;
    stall_pct = 53;
    send_random_notes(RANDOM_NOTES / 4);
    drain_results();
    idle_pct  = 30;
    stall_pct = 30;
    send_random_notes(RANDOM_NOTES / 4);
    drain_results();

    // Let anything stray come out before judging.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_setups.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
